>>> design/tpsrms_pkg.sv
// Shared types, constants and helper functions of the three-phase RMS and power accumulator.
package tpsrms_pkg;

    localparam int RING_DEPTH   = 128;
    localparam int SAMPLE_BITS  = 12;
    localparam int AW           = $clog2(RING_DEPTH);
    localparam int NW           = $clog2(RING_DEPTH + 1);
    localparam int CNT_W        = $clog2(RING_DEPTH + 2);
    localparam int CFG_W        = 8;
    localparam int RING_LEN_W   = 8;
    localparam int WIN_LEN_W    = 7;
    localparam int MIN_LEN      = 5;
    localparam int OFFSET_LIMIT = 20;
    localparam int OFF_W        = 5;
    localparam int PHASE_LAG    = 4;
    localparam int TEMP_W       = 20;
    localparam int OP_W         = SAMPLE_BITS + 2;
    localparam int PROD_W       = 2 * OP_W;
    localparam int SUM_W        = 32;
    localparam int NUM_CH       = 7;
    localparam int NUM_SUMS     = 8;
    localparam int OP_CNT_W     = 4;
    localparam int DIV_STEPS    = TEMP_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = 1;
    localparam int Q_CNT_W      = 2;

    // Sequencer slots of the shared multiplier
    localparam logic [OP_CNT_W-1:0] OP_OLD_FIRST = 4'd7;
    localparam logic [OP_CNT_W-1:0] OP_PWR_ADD   = 4'd14;
    localparam logic [OP_CNT_W-1:0] OP_PWR_SUB   = 4'd15;

    typedef enum logic [1:0] {
        CFG_RING_LEN,
        CFG_WINDOW_LEN,
        CFG_ZERO_CUR_EN,
        CFG_REVERSE
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CH_UAB,
        CH_UBC,
        CH_UCA,
        CH_IA,
        CH_IB,
        CH_IC,
        CH_NEU,
        CH_PWR
    } sum_sel_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] uab;
        logic signed [SAMPLE_BITS-1:0] ubc;
        logic signed [SAMPLE_BITS-1:0] neutral_current;
        logic signed [SAMPLE_BITS-1:0] ia;
        logic signed [SAMPLE_BITS-1:0] ic;
        logic signed [SAMPLE_BITS-1:0] temperature;
    } scan_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]       sq_sum_uab;
        logic signed [SUM_W-1:0]       sq_sum_ubc;
        logic signed [SUM_W-1:0]       sq_sum_uca;
        logic signed [SUM_W-1:0]       sq_sum_ia;
        logic signed [SUM_W-1:0]       sq_sum_ib;
        logic signed [SUM_W-1:0]       sq_sum_ic;
        logic signed [SUM_W-1:0]       sq_sum_neutral;
        logic signed [SUM_W-1:0]       power_sum;
        logic        [SAMPLE_BITS-1:0] temp_average;
        logic                          temp_valid;
        logic                          window_full;
    } result_t;

    // Classified scan handed from the front end to the back end
    typedef struct packed {
        logic signed [OP_W-1:0]        uab;
        logic signed [OP_W-1:0]        ubc;
        logic signed [OP_W-1:0]        uca;
        logic signed [OP_W-1:0]        ia;
        logic signed [OP_W-1:0]        ib;
        logic signed [OP_W-1:0]        ic;
        logic signed [OP_W-1:0]        neu;
        logic        [SAMPLE_BITS-1:0] t_off;
        logic                          wfull;
    } work_t;

    typedef struct packed {
        logic              start;
        logic [TEMP_W-1:0] dividend;
        logic [NW-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TEMP_W-1:0] quot;
        logic [NW-1:0]     rem;
    } div_rsp_t;

    function automatic logic [NW-1:0] eff_len(input logic [RING_LEN_W-1:0] rl);
        logic [NW-1:0] v;
        if (int'(rl) > RING_DEPTH) v = NW'(RING_DEPTH);
        else if (int'(rl) < MIN_LEN) v = NW'(MIN_LEN);
        else v = NW'(rl);
        return v;
    endfunction

    function automatic logic [NW-1:0] eff_win(input logic [WIN_LEN_W-1:0] wl,
                                              input logic [NW-1:0] n);
        logic [NW-1:0] v;
        if (int'(wl) > int'(n) - MIN_LEN) v = n - NW'(MIN_LEN);
        else v = NW'(wl);
        return v;
    endfunction

endpackage

>>> design/tpsrms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpsrms_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/tpsrms_div.sv
// Shared restoring divider, one quotient bit per cycle.
module tpsrms_div import tpsrms_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TEMP_W-1:0]    dvd_reg;
    logic [NW-1:0]        rem_reg;
    logic [NW-1:0]        dsr_reg;
    logic [NW:0]          rem_shift;
    logic [NW:0]          rem_sub;
    logic                 fits;
    logic [NW-1:0]        rem_next;
    logic                 load;

    assign load      = req.start && !busy_reg;
    assign rem_shift = {rem_reg, dvd_reg[TEMP_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_next  = fits ? rem_sub[NW-1:0] : rem_shift[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[TEMP_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> design/tpsrms_front.sv
// Front end: take scans, latch the current offset, derive channels, queue the work.
module tpsrms_front import tpsrms_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  scan_t         scan,
    input  logic [NW-1:0] n_eff,
    input  logic [NW-1:0] w_eff,
    output logic          q_valid,
    input  logic          q_pop,
    output work_t         q_item
);

    logic [CNT_W-1:0]               sample_cnt_reg;
    logic [CNT_W-1:0]               sample_cnt_next;
    logic [OFF_W-1:0]               offset_reg;
    logic [OFF_W-1:0]               off_use;
    logic                           cnt_live;
    logic                           hit;
    logic                           take;
    logic signed [SAMPLE_BITS:0]    ia_c;
    logic signed [SAMPLE_BITS:0]    ic_c;
    logic signed [SAMPLE_BITS:0]    off_ext;
    work_t                          entry;
    work_t                          q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]             wp_reg;
    logic [Q_PTR_W-1:0]             rp_reg;
    logic [Q_CNT_W-1:0]             q_cnt_reg;

    assign take     = push && !full;
    assign cnt_live = sample_cnt_reg <= CNT_W'(n_eff);
    assign hit      = (scan.ia > 0) && (scan.ia < OFFSET_LIMIT);
    assign off_use  = (cnt_live && hit) ? scan.ia[OFF_W-1:0] : offset_reg;
    assign sample_cnt_next = cnt_live ? sample_cnt_reg + 1'b1 : sample_cnt_reg;

    // Subtract the offset from both measured phase currents
    assign off_ext = signed'({{(SAMPLE_BITS + 1 - OFF_W){1'b0}}, off_use});
    assign ia_c    = (SAMPLE_BITS + 1)'(scan.ia) - off_ext;
    assign ic_c    = (SAMPLE_BITS + 1)'(scan.ic) - off_ext;

    always_comb
    begin
        entry.uab   = OP_W'(scan.uab);
        entry.ubc   = OP_W'(scan.ubc);
        entry.uca   = -OP_W'(scan.uab) - OP_W'(scan.ubc);
        entry.ia    = OP_W'(ia_c);
        entry.ic    = OP_W'(ic_c);
        entry.ib    = -OP_W'(ia_c) - OP_W'(ic_c);
        entry.neu   = OP_W'(scan.neutral_current);
        entry.t_off = {~scan.temperature[SAMPLE_BITS-1], scan.temperature[SAMPLE_BITS-2:0]};
        entry.wfull = sample_cnt_next >= CNT_W'(w_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cnt_reg <= '0;
            offset_reg     <= '0;
            wp_reg         <= '0;
            rp_reg         <= '0;
            q_cnt_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                sample_cnt_reg <= sample_cnt_next;
                offset_reg     <= off_use;
                wp_reg         <= wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + Q_CNT_W'(take) - Q_CNT_W'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_mem_reg[wp_reg] <= entry;
        end
    end

    assign full    = q_cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign q_valid = q_cnt_reg != '0;
    assign q_item  = q_mem_reg[rp_reg];

endmodule

>>> design/tpsrms_back.sv
// Back end: ring stores, window index arithmetic, shared multiplier and the sums.
module tpsrms_back import tpsrms_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  work_t         q_item,
    output logic          q_pop,
    input  logic [NW-1:0] n_eff,
    input  logic [NW-1:0] w_eff,
    input  logic          zce,
    input  logic          rev,
    output div_req_t      div_req,
    input  div_rsp_t      div_rsp,
    output logic          empty,
    input  logic          pop,
    output result_t       result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_POS,
        S_WRITE,
        S_RD_OLD1,
        S_RD_LAG,
        S_RD_OLD2,
        S_RD_DONE,
        S_MUL,
        S_TEMP,
        S_DIV_TEMP,
        S_DONE
    } state_t;

    state_t                   state_reg;
    work_t                    item_reg;
    logic [AW-1:0]            write_pos_reg;
    logic [AW-1:0]            pos_reg;
    logic [NW-1:0]            rem_reg;
    logic [AW-1:0]            old1_reg;
    logic [AW-1:0]            lag_reg;
    logic [AW-1:0]            old2_reg;
    logic [RING_DEPTH-1:0]    vld_main_reg;
    logic [RING_DEPTH-1:0]    vld_neu_reg;
    logic                     vld_rd_main_reg;
    logic                     vld_rd_neu_reg;
    logic signed [OP_W-1:0]   old_reg [NUM_CH];
    logic signed [OP_W-1:0]   uab_lag_reg;
    logic signed [OP_W-1:0]   uab_old2_reg;
    logic signed [OP_W-1:0]   ia_lag_reg;
    logic signed [OP_W-1:0]   ia_old2_reg;
    logic [OP_CNT_W-1:0]      op_reg;
    logic                     prod_en_reg;
    logic signed [PROD_W-1:0] prod_reg;
    sum_sel_t                 prod_dst_reg;
    logic                     prod_sub_reg;
    logic [SUM_W-1:0]         sums_reg [NUM_SUMS];
    logic [TEMP_W-1:0]        temp_acc_reg;
    logic [SAMPLE_BITS-1:0]   temp_avg_reg;
    logic                     wrap_reg;
    logic                     res_valid_reg;
    result_t                  res_reg;

    logic signed [OP_W-1:0]   nv [NUM_CH];
    logic [OP_W-1:0]          ring_rd [NUM_CH];
    logic signed [OP_W-1:0]   rd_m [NUM_CH];
    logic [NUM_CH-1:0]        ring_we;
    logic [AW-1:0]            rd_addr;
    logic [NW:0]              old1_sum;
    logic [NW:0]              lag_sum;
    logic [NW:0]              old2_sum;
    logic [NW-1:0]            old1_c;
    logic [NW-1:0]            lag_c;
    logic [NW-1:0]            old2_c;
    logic [AW:0]              pos_inc;
    logic                     wrap_c;
    logic [2:0]               ch;
    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    sum_sel_t                 mul_dst;
    logic                     mul_sub;
    logic                     mul_en;
    logic [SUM_W-1:0]         prod_ext;
    logic                     res_load;

    assign nv[CH_UAB] = item_reg.uab;
    assign nv[CH_UBC] = item_reg.ubc;
    assign nv[CH_UCA] = item_reg.uca;
    assign nv[CH_IA]  = item_reg.ia;
    assign nv[CH_IB]  = item_reg.ib;
    assign nv[CH_IC]  = item_reg.ic;
    assign nv[CH_NEU] = item_reg.neu;

    // Window positions: remainder of the write position plus one conditional wrap each
    assign old1_sum = {1'b0, rem_reg} + {1'b0, n_eff} - {1'b0, w_eff};
    assign old1_c   = (old1_sum >= {1'b0, n_eff}) ? old1_sum[NW-1:0] - n_eff : old1_sum[NW-1:0];
    assign lag_sum  = {1'b0, rem_reg} + {1'b0, n_eff} - (NW + 1)'(PHASE_LAG);
    assign lag_c    = (lag_sum >= {1'b0, n_eff}) ? lag_sum[NW-1:0] - n_eff : lag_sum[NW-1:0];
    assign old2_sum = {1'b0, old1_c} + {1'b0, n_eff} - (NW + 1)'(PHASE_LAG);
    assign old2_c   = (old2_sum >= {1'b0, n_eff}) ? old2_sum[NW-1:0] - n_eff : old2_sum[NW-1:0];

    assign pos_inc = {1'b0, write_pos_reg} + 1'b1;
    assign wrap_c  = int'(pos_inc) >= int'(n_eff);

    always_comb
    begin
        case (state_reg)
            S_RD_LAG:  rd_addr = lag_reg;
            S_RD_OLD2: rd_addr = old2_reg;
            default:   rd_addr = old1_reg;
        endcase
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_ring
        assign ring_we[c] = (state_reg == S_WRITE) && ((c != int'(CH_NEU)) || zce);
        assign rd_m[c]    = ((c == int'(CH_NEU)) ? vld_rd_neu_reg : vld_rd_main_reg)
                            ? signed'(ring_rd[c]) : '0;

        tpsrms_ram #(
            .WIDTH (OP_W),
            .DEPTH (RING_DEPTH)
        ) u_ring (
            .clk   (clk),
            .we    (ring_we[c]),
            .waddr (pos_reg),
            .wdata (nv[c]),
            .raddr (rd_addr),
            .rdata (ring_rd[c])
        );
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        ch      = '0;
        mul_a   = nv[CH_UAB];
        mul_b   = nv[CH_UAB];
        mul_dst = CH_PWR;
        mul_sub = 1'b0;
        mul_en  = 1'b1;
        if (op_reg < OP_OLD_FIRST)
        begin
            ch      = op_reg[2:0];
            mul_a   = nv[ch];
            mul_b   = nv[ch];
            mul_dst = sum_sel_t'(ch);
            mul_en  = (sum_sel_t'(ch) != CH_NEU) || zce;
        end
        else if (op_reg < OP_PWR_ADD)
        begin
            ch      = 3'(op_reg - OP_OLD_FIRST);
            mul_a   = old_reg[ch];
            mul_b   = old_reg[ch];
            mul_dst = sum_sel_t'(ch);
            mul_sub = 1'b1;
            mul_en  = (sum_sel_t'(ch) != CH_NEU) || zce;
        end
        else if (op_reg == OP_PWR_ADD)
        begin
            mul_a = rev ? nv[CH_UAB] : uab_lag_reg;
            mul_b = rev ? ia_lag_reg : nv[CH_IA];
        end
        else
        begin
            mul_a   = rev ? old_reg[CH_UAB] : uab_old2_reg;
            mul_b   = rev ? ia_old2_reg : old_reg[CH_IA];
            mul_sub = 1'b1;
        end
    end

    assign prod_ext = SUM_W'(prod_reg);
    assign res_load = (state_reg == S_DONE) && (!res_valid_reg || pop);

    assign q_pop            = (state_reg == S_IDLE) && q_valid;
    assign div_req.start    = q_pop || ((state_reg == S_TEMP) && wrap_reg);
    assign div_req.dividend = (state_reg == S_IDLE) ? TEMP_W'(write_pos_reg) : temp_acc_reg;
    assign div_req.divisor  = n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            write_pos_reg <= '0;
            temp_acc_reg  <= '0;
            temp_avg_reg  <= '0;
            vld_main_reg  <= '0;
            vld_neu_reg   <= '0;
            prod_en_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_SUMS; k++)
            begin
                sums_reg[k] <= '0;
            end
        end
        else
        begin
            prod_en_reg <= (state_reg == S_MUL) && mul_en;
            if (prod_en_reg)
            begin
                sums_reg[prod_dst_reg] <= prod_sub_reg ? sums_reg[prod_dst_reg] - prod_ext
                                                       : sums_reg[prod_dst_reg] + prod_ext;
            end
            // Hold the result until popped; a new one may replace it in the pop cycle
            res_valid_reg <= res_load || (res_valid_reg && !pop);
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        temp_acc_reg  <= temp_acc_reg + TEMP_W'(q_item.t_off);
                        write_pos_reg <= wrap_c ? '0 : pos_inc[AW-1:0];
                        state_reg     <= S_DIV_POS;
                    end
                end
                S_DIV_POS:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    vld_main_reg[pos_reg] <= 1'b1;
                    if (zce)
                    begin
                        vld_neu_reg[pos_reg] <= 1'b1;
                    end
                    state_reg <= S_RD_OLD1;
                end
                S_RD_OLD1: state_reg <= S_RD_LAG;
                S_RD_LAG:  state_reg <= S_RD_OLD2;
                S_RD_OLD2: state_reg <= S_RD_DONE;
                S_RD_DONE: state_reg <= S_MUL;
                S_MUL:
                begin
                    if (op_reg == OP_PWR_SUB)
                    begin
                        state_reg <= S_TEMP;
                    end
                end
                S_TEMP:
                begin
                    state_reg <= wrap_reg ? S_DIV_TEMP : S_DONE;
                end
                S_DIV_TEMP:
                begin
                    if (div_rsp.done)
                    begin
                        temp_avg_reg <= div_rsp.quot[SAMPLE_BITS-1:0];
                        temp_acc_reg <= '0;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        vld_rd_main_reg <= vld_main_reg[rd_addr];
        vld_rd_neu_reg  <= vld_neu_reg[rd_addr];
        prod_reg        <= mul_a * mul_b;
        prod_dst_reg    <= mul_dst;
        prod_sub_reg    <= mul_sub;
        if (q_pop)
        begin
            item_reg <= q_item;
            pos_reg  <= write_pos_reg;
            wrap_reg <= wrap_c;
        end
        if ((state_reg == S_DIV_POS) && div_rsp.done)
        begin
            rem_reg <= div_rsp.rem;
        end
        if (state_reg == S_WRITE)
        begin
            old1_reg <= old1_c[AW-1:0];
            lag_reg  <= lag_c[AW-1:0];
            old2_reg <= old2_c[AW-1:0];
        end
        if (state_reg == S_RD_LAG)
        begin
            for (int k = 0; k < NUM_CH; k++)
            begin
                old_reg[k] <= rd_m[k];
            end
        end
        if (state_reg == S_RD_OLD2)
        begin
            uab_lag_reg <= rd_m[CH_UAB];
            ia_lag_reg  <= rd_m[CH_IA];
        end
        if (state_reg == S_RD_DONE)
        begin
            uab_old2_reg <= rd_m[CH_UAB];
            ia_old2_reg  <= rd_m[CH_IA];
            op_reg       <= '0;
        end
        else if (state_reg == S_MUL)
        begin
            op_reg <= op_reg + 1'b1;
        end
        if (res_load)
        begin
            res_reg.sq_sum_uab     <= sums_reg[CH_UAB];
            res_reg.sq_sum_ubc     <= sums_reg[CH_UBC];
            res_reg.sq_sum_uca     <= sums_reg[CH_UCA];
            res_reg.sq_sum_ia      <= sums_reg[CH_IA];
            res_reg.sq_sum_ib      <= sums_reg[CH_IB];
            res_reg.sq_sum_ic      <= sums_reg[CH_IC];
            res_reg.sq_sum_neutral <= sums_reg[CH_NEU];
            res_reg.power_sum      <= sums_reg[CH_PWR];
            res_reg.temp_average   <= temp_avg_reg;
            res_reg.temp_valid     <= wrap_reg;
            res_reg.window_full    <= item_reg.wfull;
        end
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

>>> design/three_phase_sliding_rms_power_accum_core.sv
// Top level of the three-phase sliding-window RMS and power accumulator.
//
// One item is one ADC scan (Uab, Ubc, neutral current, Ia, Ic, temperature) and
// yields exactly one result: eight 32-bit wrapping window sums (squares of Uab,
// Ubc, derived Uca, offset-corrected Ia and Ic, derived Ib, neutral current,
// and the voltage-current power sum with a four-sample lag), the latest mean
// temperature, a flag for a scan that closed the ring period, and a flag for
// a full window. For each scan the write position is first reduced modulo
// the ring length by the shared 20-step divider, the ring stores then take
// one write and three reads, and one shared multiplier works through sixteen
// products; closing a period runs the divider once more for the temperature
// mean. A two-entry queue sits ahead of that engine, so scans are taken while
// earlier ones are in work and a result waits in its output register until
// popped. The ring stores need no clearing pass: a valid bit per entry makes
// unwritten entries read as zero from reset. Write the configuration registers
// only while idle.
module three_phase_sliding_rms_power_accum_core import tpsrms_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  scan_t            scan,
    output logic             empty,
    input  logic             pop,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [RING_LEN_W-1:0] ring_len_reg;
    logic [WIN_LEN_W-1:0]  window_len_reg;
    logic                  zce_reg;
    logic                  rev_reg;
    logic [NW-1:0]         n_eff;
    logic [NW-1:0]         w_eff;
    logic                  q_valid;
    logic                  q_pop;
    work_t                 q_item;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // Configuration registers; hold their value between writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_len_reg   <= RING_LEN_W'(100);
            window_len_reg <= WIN_LEN_W'(64);
            zce_reg        <= 1'b0;
            rev_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RING_LEN:    ring_len_reg   <= cfg_data[RING_LEN_W-1:0];
                CFG_WINDOW_LEN:  window_len_reg <= cfg_data[WIN_LEN_W-1:0];
                CFG_ZERO_CUR_EN: zce_reg        <= cfg_data[0];
                CFG_REVERSE:     rev_reg        <= cfg_data[0];
                default:         rev_reg        <= rev_reg;
            endcase
        end
    end

    // Clamp the ring length into range, then the window to five short of it
    assign n_eff = eff_len(ring_len_reg);
    assign w_eff = eff_win(window_len_reg, n_eff);

    tpsrms_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .scan    (scan),
        .n_eff   (n_eff),
        .w_eff   (w_eff),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    tpsrms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tpsrms_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .n_eff   (n_eff),
        .w_eff   (w_eff),
        .zce     (zce_reg),
        .rev     (rev_reg),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // Divider is never restarted while a division is running
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A started division is under way in the next cycle
    a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> div_rsp.busy)
        else $error("divider did not start");

    // Completion only follows a running division
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> $past(div_rsp.busy))
        else $error("divider done without a division");

    // The back end drains the queue only when it holds an item
    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty work queue");

endmodule

>>> test/tb_three_phase_sliding_rms_power_accum_core.sv
// Self-checking testbench for the three-phase sliding-window RMS and power accumulator.
`timescale 1ns / 1ps

module tb_three_phase_sliding_rms_power_accum_core;
    import tpsrms_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    scan_t            scan = '0;
    logic             empty;
    logic             pop = 1'b0;
    result_t          result;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    three_phase_sliding_rms_power_accum_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .scan      (scan),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Predictor state: a private copy of the rings, sums and registers
    logic [7:0]        m_ring_len;
    logic [6:0]        m_window_len;
    logic              m_neutral_en;
    logic              m_reverse;
    logic signed [31:0] r_uab [RING_DEPTH];
    logic signed [31:0] r_ubc [RING_DEPTH];
    logic signed [31:0] r_uca [RING_DEPTH];
    logic signed [31:0] r_ia  [RING_DEPTH];
    logic signed [31:0] r_ib  [RING_DEPTH];
    logic signed [31:0] r_ic  [RING_DEPTH];
    logic signed [31:0] r_neu [RING_DEPTH];
    logic [31:0]       sums [NUM_SUMS];
    int unsigned       wr_pos;
    int unsigned       scan_count;
    int                cur_offset;
    logic [19:0]       temp_acc;
    logic [11:0]       temp_avg;

    scan_t   pending_scans[$];
    result_t expected_results[$];
    int      mismatches = 0;
    bit      quiet_tail = 1'b0;   // no idling in the last part of the run

    // Clear every ring and sum; registers back to their reset values
    task automatic model_reset();
        m_ring_len = 8'd100;
        m_window_len = 7'd64;
        m_neutral_en = 1'b0;
        m_reverse = 1'b0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            r_uab[i] = 0; r_ubc[i] = 0; r_uca[i] = 0; r_ia[i] = 0;
            r_ib[i] = 0; r_ic[i] = 0; r_neu[i] = 0;
        end
        for (int k = 0; k < NUM_SUMS; k++)
            sums[k] = '0;
        wr_pos = 0;
        scan_count = 0;
        cur_offset = 0;
        temp_acc = '0;
        temp_avg = '0;
    endtask

    function automatic logic [31:0] sq(input int v);
        logic signed [63:0] p;
        p = longint'(v) * longint'(v);
        return p[31:0];
    endfunction

    function automatic logic [31:0] prod(input int a, input int b);
        logic signed [63:0] p;
        p = longint'(a) * longint'(b);
        return p[31:0];
    endfunction

    // Work out the result of one accepted scan and advance the predictor
    task automatic predict_scan(input scan_t s);
        int unsigned n, w, pos, old1, old2, lag;
        int uab, ubc, uca, neu, ia, ic, ib, t;
        result_t r;
        n = m_ring_len;
        w = m_window_len;
        if (n > RING_DEPTH) n = RING_DEPTH;
        if (n < MIN_LEN) n = MIN_LEN;
        if (w > n - MIN_LEN) w = n - MIN_LEN;
        pos = wr_pos % RING_DEPTH;
        uab = s.uab; ubc = s.ubc; neu = s.neutral_current;
        ia = s.ia; ic = s.ic; t = s.temperature;
        if (scan_count <= n)
        begin
            scan_count++;
            if (ia > 0 && ia < OFFSET_LIMIT) cur_offset = ia;
        end
        uca = -uab - ubc;
        ia = ia - cur_offset;
        ic = ic - cur_offset;
        ib = -ia - ic;
        temp_acc = temp_acc + 20'(t + 2048);
        old1 = (pos + n - w) % n;
        old2 = (old1 + n - PHASE_LAG) % n;
        lag = (pos + n - PHASE_LAG) % n;
        // Write first, then subtract the square leaving the window
        r_uab[pos] = uab; sums[CH_UAB] = sums[CH_UAB] + sq(uab) - sq(r_uab[old1]);
        r_ubc[pos] = ubc; sums[CH_UBC] = sums[CH_UBC] + sq(ubc) - sq(r_ubc[old1]);
        r_uca[pos] = uca; sums[CH_UCA] = sums[CH_UCA] + sq(uca) - sq(r_uca[old1]);
        r_ia[pos] = ia;   sums[CH_IA] = sums[CH_IA] + sq(ia) - sq(r_ia[old1]);
        r_ic[pos] = ic;   sums[CH_IC] = sums[CH_IC] + sq(ic) - sq(r_ic[old1]);
        r_ib[pos] = ib;   sums[CH_IB] = sums[CH_IB] + sq(ib) - sq(r_ib[old1]);
        if (m_neutral_en)
        begin
            r_neu[pos] = neu;
            sums[CH_NEU] = sums[CH_NEU] + sq(neu) - sq(r_neu[old1]);
        end
        if (!m_reverse)
            sums[CH_PWR] = sums[CH_PWR] + prod(r_uab[lag], r_ia[pos])
                           - prod(r_uab[old2], r_ia[old1]);
        else
            sums[CH_PWR] = sums[CH_PWR] + prod(r_uab[pos], r_ia[lag])
                           - prod(r_uab[old1], r_ia[old2]);
        r.temp_valid = 1'b0;
        pos++;
        if (pos >= n)
        begin
            temp_avg = 12'(temp_acc / n);
            temp_acc = '0;
            pos = 0;
            r.temp_valid = 1'b1;
        end
        wr_pos = pos;
        r.sq_sum_uab = sums[CH_UAB];
        r.sq_sum_ubc = sums[CH_UBC];
        r.sq_sum_uca = sums[CH_UCA];
        r.sq_sum_ia = sums[CH_IA];
        r.sq_sum_ib = sums[CH_IB];
        r.sq_sum_ic = sums[CH_IC];
        r.sq_sum_neutral = sums[CH_NEU];
        r.power_sum = sums[CH_PWR];
        r.temp_average = temp_avg;
        r.window_full = (scan_count >= w);
        expected_results.push_back(r);
    endtask

    // Driver: present queued scans, predict each one as it is accepted
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predict_scan(scan);
            if (push && full)
                ;   // hold the item until it is taken
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end
            else if (pending_scans.size() > 0 && !(push && !full && !quiet_tail
                     && $urandom_range(0, 9) == 0))
            begin
                scan <= pending_scans.pop_front();
                push <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
                if (!quiet_tail && pending_scans.size() > 0)
                    send_gap <= $urandom_range(0, 16);
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    int pop_gap = 0;
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %h", result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result mismatch\n  expected %h\n  actual   %h",
                                     want, result);
                    end
                end
            end
            // Stall in random bursts, except during the quiet tail
            if (pop_gap > 0)
            begin
                pop_gap <= pop_gap - 1;
                pop <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 14) == 0)
            begin
                pop_gap <= $urandom_range(0, 16);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Drain: wait for every queued item to go and every result to arrive
    task automatic drain();
        while (pending_scans.size() > 0 || push || expected_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Registers are only written here, while the block is idle
    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RING_LEN:    m_ring_len = val;
            CFG_WINDOW_LEN:  m_window_len = val[6:0];
            CFG_ZERO_CUR_EN: m_neutral_en = val[0];
            default:         m_reverse = val[0];
        endcase
    endtask

    function automatic logic [11:0] rnd_sample();
        case ($urandom_range(0, 7))
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return 12'(int'($urandom_range(0, 24)) - 2);
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic scan_t rnd_scan();
        scan_t s;
        s.uab = rnd_sample();
        s.ubc = rnd_sample();
        s.neutral_current = rnd_sample();
        s.ia = rnd_sample();
        s.ic = rnd_sample();
        s.temperature = rnd_sample();
        return s;
    endfunction

    // Stimulus in phases, one register setting per phase
    initial
    begin
        scan_t s;
        logic [7:0] rl;
        model_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes of every field, offset window edges
        s = '{12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF};
        pending_scans.push_back(s);
        s = '{12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800};
        pending_scans.push_back(s);
        for (int i = 0; i < 12; i++)
        begin
            s = '0;
            s.ia = 12'(i * 2 + 1);   // odd values around the offset window, 1..23
            s.uab = 12'sd100;
            pending_scans.push_back(s);
        end
        s = '0; s.ia = 12'd19; pending_scans.push_back(s);
        s = '0; s.ia = 12'd20; pending_scans.push_back(s);
        s = '0; s.ia = 12'd0;  pending_scans.push_back(s);
        drain();   // sender pauses until every result is in

        // Smallest ring: window clamps to zero
        write_reg(CFG_RING_LEN, 8'd5);
        write_reg(CFG_WINDOW_LEN, 8'd127);
        write_reg(CFG_ZERO_CUR_EN, 8'd1);
        write_reg(CFG_REVERSE, 8'd1);
        repeat (20) pending_scans.push_back(rnd_scan());
        drain();

        // Random phases across several settings, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: rl = 8'd128;
                1: rl = 8'd255;
                2: rl = 8'd0;
                3: rl = 8'd6;
                default: rl = 8'($urandom_range(5, 128));
            endcase
            write_reg(CFG_RING_LEN, rl);
            write_reg(CFG_WINDOW_LEN, ph == 0 ? 8'd123 : ph == 3 ? 8'd1
                                                       : 8'($urandom_range(0, 127)));
            write_reg(CFG_ZERO_CUR_EN, 8'($urandom_range(0, 1)));
            write_reg(CFG_REVERSE, 8'($urandom_range(0, 1)));
            if (ph == 7) quiet_tail = 1'b1;
            repeat (250) pending_scans.push_back(rnd_scan());
            drain();
        end
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: about 2000 items plus gaps, many times over
    initial
    begin
        #(12 * 3000000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
